// ===== src/mke_pkg.sv =====
// Morse keyer encoder package: request and result structs, request codes,
// register map and the character-to-code tables. No dependencies.
package mke_pkg;

  localparam int MSG_LEN = 64;
  localparam int ADDR_W  = $clog2(MSG_LEN);
  localparam int CNT_W   = $clog2(MSG_LEN + 1);

  localparam logic [1:0] REQ_TICK   = 2'd0;
  localparam logic [1:0] REQ_APPEND = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  localparam logic REG_DOT_TICKS = 1'b0;

  localparam logic [7:0] DOT_TICKS_RESET = 8'd15;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] char_code;
  } mke_in_t;

  typedef struct packed {
    logic       key_on;
    logic       active;
    logic [6:0] chars_sent;
    logic       append_rejected;
  } mke_out_t;

  // bit i set: element i is a dash
  localparam logic [4:0] DIGIT_PAT [10] = '{
    5'h1F, 5'h1E, 5'h1C, 5'h18, 5'h10, 5'h00, 5'h01, 5'h03, 5'h07, 5'h0F
  };

  localparam logic [2:0] LETTER_LEN [26] = '{
    3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
    3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
  };

  localparam logic [4:0] LETTER_PAT [26] = '{
    5'h2, 5'h1, 5'h5, 5'h1, 5'h0, 5'h4, 5'h3, 5'h0, 5'h0, 5'hE, 5'h5, 5'h2, 5'h3,
    5'h1, 5'h7, 5'h6, 5'hB, 5'h2, 5'h0, 5'h1, 5'h4, 5'h8, 5'h6, 5'h9, 5'hD, 5'h3
  };

  // element count; zero for characters that send nothing
  function automatic logic [2:0] code_len(input logic [7:0] ch);
    logic [2:0] len;
    len = 3'd0;
    if (ch >= CH_0 && ch <= CH_9) begin
      len = 3'd5;
    end else if (ch >= CH_UA && ch <= CH_UZ) begin
      len = LETTER_LEN[5'(ch - CH_UA)];
    end else if (ch >= CH_LA && ch <= CH_LZ) begin
      len = LETTER_LEN[5'(ch - CH_LA)];
    end
    return len;
  endfunction

  function automatic logic [4:0] code_pat(input logic [7:0] ch);
    logic [4:0] pat;
    pat = 5'd0;
    if (ch >= CH_0 && ch <= CH_9) begin
      pat = DIGIT_PAT[4'(ch - CH_0)];
    end else if (ch >= CH_UA && ch <= CH_UZ) begin
      pat = LETTER_PAT[5'(ch - CH_UA)];
    end else if (ch >= CH_LA && ch <= CH_LZ) begin
      pat = LETTER_PAT[5'(ch - CH_LA)];
    end
    return pat;
  endfunction

endpackage

// ===== src/mke_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mke_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/morse_keyer_encoder.sv =====
// Morse keyer encoder top level: message buffer, keying state, APB register.
// Depends on mke_pkg and mke_ram.
// Results are registered, through the skid register when the output is stalled.
// Throughput: one request per cycle unless stalled; two buffer copies give
// the current and the following character each cycle, write-forwarded on both.
// Reset clears all control state and sets dot_ticks to 15; the message
// buffer is not cleared and is only read below the write count.
module morse_keyer_encoder (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  mke_pkg::mke_in_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output mke_pkg::mke_out_t out_data,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int AW = mke_pkg::ADDR_W;
  localparam int CW = mke_pkg::CNT_W;

  logic [7:0]    dot_ticks_r;
  logic [CW-1:0] wc_r, wc_nxt;
  logic [CW-1:0] ri_r, ri_nxt;
  logic [10:0]   tick_r, tick_nxt;
  logic [3:0]    seg_r, seg_nxt;
  logic          snd_r, snd_nxt;
  logic [10:0]   gap_r, gap_nxt;

  logic          fwd0_r, fwd1_r;
  logic [7:0]    fwd_data_r;
  logic [7:0]    q0, q1, ch0, ch1;

  logic             out_valid_r, skid_valid_r;
  mke_pkg::mke_out_t out_data_r, skid_data_r, res;

  logic          acc, we, out_free;
  logic [AW-1:0] raddr0, raddr1;
  logic [CW-1:0] ri_nxt_inc;

  assign acc      = in_valid && !skid_valid_r;
  assign in_stall = skid_valid_r;
  assign out_free = !out_valid_r || !out_stall;

  assign ch0 = fwd0_r ? fwd_data_r : q0;
  assign ch1 = fwd1_r ? fwd_data_r : q1;

  // request processing
  always_comb begin
    logic [9:0]  dot3, dur;
    logic [10:0] dot7, tc;
    logic [2:0]  len;
    logic [7:0]  pat8;
    logic [3:0]  span, seg_inc;
    logic [CW-1:0] ri1, ri2;
    logic        busy, zeroed, key, rej;

    wc_nxt   = wc_r;
    ri_nxt   = ri_r;
    tick_nxt = tick_r;
    seg_nxt  = seg_r;
    snd_nxt  = snd_r;
    gap_nxt  = gap_r;
    we       = 1'b0;
    key      = 1'b0;
    rej      = 1'b0;
    busy     = 1'b0;
    zeroed   = 1'b0;
    dur      = '0;
    tc       = '0;

    dot3    = {2'b00, dot_ticks_r} + {1'b0, dot_ticks_r, 1'b0};
    dot7    = {dot_ticks_r, 3'b000} - {3'b000, dot_ticks_r};
    len     = mke_pkg::code_len(ch0);
    pat8    = {3'b000, mke_pkg::code_pat(ch0)};
    span    = {len, 1'b0};
    seg_inc = seg_r + 4'd1;
    ri1     = ri_r + CW'(1);
    ri2     = ri_r + CW'(2);

    if (acc) begin
      unique case (in_data.req_type)
        mke_pkg::REQ_TICK: begin
          if (snd_r) begin
            if (seg_r < span) begin
              if (!seg_r[0]) begin
                dur = pat8[seg_r[3:1]] ? dot3 : {2'b00, dot_ticks_r};
                key = 1'b1;
              end else begin
                dur = {2'b00, dot_ticks_r};
              end
              tc = tick_r + 11'd1;
              if (tc >= {1'b0, dur}) begin
                tc      = '0;
                seg_nxt = seg_inc;
                if (seg_inc >= 4'(span - 4'd1)) begin
                  seg_nxt = '0;
                  zeroed  = 1'b1;
                end
              end
              tick_nxt = tc;
            end
            busy = !zeroed && (seg_nxt < span);
          end else begin
            tc = tick_r + 11'd1;
            if (tc >= gap_r) begin
              tc = '0;
            end
            tick_nxt = tc;
            busy     = tc != 11'd0;
          end
          if (!busy) begin
            if (snd_r) begin
              snd_nxt = 1'b0;
              if (ri1 < wc_r && ch1 == mke_pkg::CH_SPACE) begin
                gap_nxt = dot7;
                ri_nxt  = ri2;
              end else begin
                gap_nxt = {1'b0, dot3};
                ri_nxt  = ri1;
              end
            end else if (ri_r < wc_r) begin
              snd_nxt = 1'b1;
            end
          end
        end
        mke_pkg::REQ_APPEND: begin
          if (wc_r < CW'(mke_pkg::MSG_LEN)) begin
            we     = 1'b1;
            wc_nxt = wc_r + CW'(1);
          end else begin
            rej = 1'b1;
          end
        end
        mke_pkg::REQ_CLEAR: begin
          wc_nxt   = '0;
          ri_nxt   = '0;
          tick_nxt = '0;
          seg_nxt  = '0;
          snd_nxt  = 1'b0;
          gap_nxt  = '0;
        end
        default: begin
        end
      endcase
    end

    res.key_on          = key;
    res.active          = snd_nxt || (ri_nxt < wc_nxt);
    res.chars_sent      = 7'(ri_nxt);
    res.append_rejected = rej;
  end

  assign ri_nxt_inc = ri_nxt + CW'(1);
  assign raddr0     = ri_nxt[AW-1:0];
  assign raddr1     = ri_nxt_inc[AW-1:0];

  mke_ram #(.WIDTH(8), .DEPTH(mke_pkg::MSG_LEN)) u_ram_cur (
    .clk   (clk),
    .we    (we),
    .waddr (wc_r[AW-1:0]),
    .wdata (in_data.char_code),
    .raddr (raddr0),
    .rdata (q0)
  );

  mke_ram #(.WIDTH(8), .DEPTH(mke_pkg::MSG_LEN)) u_ram_next (
    .clk   (clk),
    .we    (we),
    .waddr (wc_r[AW-1:0]),
    .wdata (in_data.char_code),
    .raddr (raddr1),
    .rdata (q1)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_ticks_r  <= mke_pkg::DOT_TICKS_RESET;
      wc_r         <= '0;
      ri_r         <= '0;
      tick_r       <= '0;
      seg_r        <= '0;
      snd_r        <= 1'b0;
      gap_r        <= '0;
      fwd0_r       <= 1'b0;
      fwd1_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (psel && penable && pwrite && paddr[2] == mke_pkg::REG_DOT_TICKS) begin
        dot_ticks_r <= pwdata[7:0];
      end
      wc_r   <= wc_nxt;
      ri_r   <= ri_nxt;
      tick_r <= tick_nxt;
      seg_r  <= seg_nxt;
      snd_r  <= snd_nxt;
      gap_r  <= gap_nxt;
      fwd0_r <= we && (wc_r[AW-1:0] == raddr0);
      fwd1_r <= we && (wc_r[AW-1:0] == raddr1);
      if (out_free) begin
        if (skid_valid_r) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end else begin
          out_valid_r <= acc;
        end
      end else if (acc) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    fwd_data_r <= in_data.char_code;
    if (out_free) begin
      out_data_r <= skid_valid_r ? skid_data_r : res;
    end else if (acc) begin
      skid_data_r <= res;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == mke_pkg::REG_DOT_TICKS) begin
      prdata = {24'd0, dot_ticks_r};
    end
  end

  assign pready    = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== src/mke_checker.sv =====
// Port-level checker for the Morse keyer encoder, bound to the top level.
// Depends on mke_pkg and morse_keyer_encoder.
module mke_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input mke_pkg::mke_in_t  in_data,
  input logic              out_valid,
  input logic              out_stall,
  input mke_pkg::mke_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result pending");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted request produced no result");

  a_nontick_key_off: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && in_valid && !in_stall && in_data.req_type != mke_pkg::REQ_TICK
    |=> !out_data.key_on)
    else $error("key on for a request that is not a tick");

endmodule

bind morse_keyer_encoder mke_checker u_mke_checker (.*);
